// ===== hw/rtl/fixed_point_taylor_sine_defines.svh =====
// Assertion macros shared by the checker of the Taylor-series sine block.
// No dependencies; taken in by `include where assertions are written.
`ifndef FIXED_POINT_TAYLOR_SINE_DEFINES_SVH
`define FIXED_POINT_TAYLOR_SINE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define FTS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// An implication checked at every clock edge outside reset.
`define FTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

`endif

// ===== hw/rtl/fts_pkg.sv =====
// Types and constants of the Taylor-series sine block.
// No dependencies; imported by every module of the block.
package fts_pkg;

    localparam int TERM_COUNT_DEF = 12;

    localparam int ANGLE_W     = 19;
    localparam int SINE_W      = 18;
    localparam int ANGLE_LIMIT = 205887;
    localparam int ONE_Q16     = 65536;
    localparam int SINE_MAX    = 131071;
    localparam int SINE_MIN    = -131072;

    // Magnitude of the angle after truncation by 256.
    localparam int XMAG_W     = 10;
    // Magnitude of one series term; the largest term stays below 2^19.
    localparam int TERM_MAG_W = 20;
    // Product of the two truncated magnitudes.
    localparam int PROD_W     = XMAG_W + TERM_MAG_W - 8;
    localparam int SUM_W      = 22;

    // Division by a small constant through a rounded-up reciprocal. With the
    // divisor below 16, the shift below is wide enough for the quotient to be
    // exact over the whole product range.
    localparam int DIV_SHIFT = PROD_W + 4;
    localparam int RECIP_W   = DIV_SHIFT + 1;

    // What a term of index k does to the sum, by k modulo 4.
    localparam logic [1:0] PHASE_ADD = 2'd1;
    localparam logic [1:0] PHASE_SUB = 2'd3;

    // Data handed from one cell of the chain to the next.
    typedef struct packed {
        logic                     valid;
        logic                     x_neg;
        logic [XMAG_W-1:0]        x_mag;
        logic                     t_neg;
        logic [TERM_MAG_W-1:0]    t_mag;
        logic signed [SUM_W-1:0]  sum;
    } fts_link_t;

endpackage

// ===== hw/rtl/fixed_point_taylor_sine.sv =====
// Channel  | Ports                     | Transfer
// ---------+---------------------------+-----------------------------------------
// input    | start, busy, angle        | edge with start high and busy low
// result   | done, sine_value          | edge that ends a cycle with done high
//
// Each item runs down a chain of TERM_COUNT-1 cells, two register stages per cell
// (the term product, then the division by the term index as a reciprocal multiply).
// An item is registered in fts_front, in both stages of every cell and in fts_final;
// the chain takes a new item in every cycle, so busy stays low.
// Reset clears the valid flags of every stage; items in flight are dropped.
// The receiver cannot stall: results leave on the cycle they appear.
//
// Top level of the Taylor-series sine block. Depends on fts_pkg, fts_front,
// fts_cell and fts_final.
module fixed_point_taylor_sine
    import fts_pkg::*;
#(
    parameter int TERM_COUNT = TERM_COUNT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                      done,
    output logic signed [SINE_W-1:0]  sine_value
);

    fts_link_t chain [TERM_COUNT];

    assign busy = 1'b0;

    fts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .angle    (angle),
        .link_out (chain[0])
    );

    for (genvar g = 1; g < TERM_COUNT; g++)
    begin : g_cell
        fts_cell #(
            .K (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (chain[g-1]),
            .link_out (chain[g])
        );
    end

    fts_final #(
        .TERM_COUNT (TERM_COUNT)
    ) u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_in    (chain[TERM_COUNT-1]),
        .done       (done),
        .sine_value (sine_value)
    );

endmodule

// ===== hw/rtl/fts_front.sv =====
// Input stage of the sine chain: clamps the angle and splits it into sign and magnitude.
// Depends on fts_pkg.
module fts_front
    import fts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [ANGLE_W-1:0] angle,
    output fts_link_t                 link_out
);

    localparam logic signed [ANGLE_W-1:0] LIM_HI = ANGLE_W'(ANGLE_LIMIT);
    localparam logic signed [ANGLE_W-1:0] LIM_LO = -LIM_HI;

    logic signed [ANGLE_W-1:0] clamped;
    logic        [ANGLE_W-1:0] abs_val;
    fts_link_t                 link_reg;
    fts_link_t                 link_next;

    always_comb
    begin
        if (angle > LIM_HI)
        begin
            clamped = LIM_HI;
        end
        else if (angle < LIM_LO)
        begin
            clamped = LIM_LO;
        end
        else
        begin
            clamped = angle;
        end
        abs_val = clamped[ANGLE_W-1] ? ANGLE_W'(-clamped) : ANGLE_W'(clamped);

        // Truncation toward zero by 256 is a shift of the magnitude.
        link_next.valid = start;
        link_next.x_neg = clamped[ANGLE_W-1];
        link_next.x_mag = abs_val[XMAG_W+7:8];
        link_next.t_neg = 1'b0;
        link_next.t_mag = TERM_MAG_W'(ONE_Q16);
        link_next.sum   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

// ===== hw/rtl/fts_cell.sv =====
// One cell of the sine chain: forms term K from term K-1; adds or subtracts term K-1 by its phase.
// Depends on fts_pkg.
module fts_cell
    import fts_pkg::*;
#(
    parameter int K = 1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  fts_link_t link_in,
    output fts_link_t link_out
);

    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_SHIFT) + 64'(K) - 64'd1) / 64'(K);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam logic [1:0]         PHASE = 2'((K - 1) % 4);
    localparam int                 QW    = PROD_W + RECIP_W;

    // First stage: product of the truncated magnitudes, sum update.
    logic                    a_valid_reg;
    logic                    a_x_neg_reg;
    logic [XMAG_W-1:0]       a_x_mag_reg;
    logic                    a_p_neg_reg;
    logic [PROD_W-1:0]       a_prod_reg;
    logic signed [SUM_W-1:0] a_sum_reg;

    logic [PROD_W-1:0]       prod_next;
    logic signed [SUM_W-1:0] term_s;
    logic signed [SUM_W-1:0] sum_next;

    // Second stage: quotient by K.
    logic [QW-1:0]           quot_full;
    fts_link_t               link_reg;
    fts_link_t               link_next;

    always_comb
    begin
        prod_next = PROD_W'(link_in.x_mag) * PROD_W'(link_in.t_mag[TERM_MAG_W-1:8]);
        term_s = link_in.t_neg ? -$signed(SUM_W'(link_in.t_mag))
                               : $signed(SUM_W'(link_in.t_mag));
        case (PHASE)
            PHASE_ADD: sum_next = link_in.sum + term_s;
            PHASE_SUB: sum_next = link_in.sum - term_s;
            default:   sum_next = link_in.sum;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_x_neg_reg <= 1'b0;
            a_x_mag_reg <= '0;
            a_p_neg_reg <= 1'b0;
            a_prod_reg  <= '0;
            a_sum_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= link_in.valid;
            a_x_neg_reg <= link_in.x_neg;
            a_x_mag_reg <= link_in.x_mag;
            a_p_neg_reg <= link_in.x_neg ^ link_in.t_neg;
            a_prod_reg  <= prod_next;
            a_sum_reg   <= sum_next;
        end
    end

    always_comb
    begin
        quot_full = QW'(a_prod_reg) * QW'(RECIP);

        link_next.valid = a_valid_reg;
        link_next.x_neg = a_x_neg_reg;
        link_next.x_mag = a_x_mag_reg;
        link_next.t_neg = a_p_neg_reg;
        link_next.t_mag = quot_full[DIV_SHIFT +: TERM_MAG_W];
        link_next.sum   = a_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

// ===== hw/rtl/fts_final.sv =====
// Output stage of the sine chain: adds or subtracts the last term by its phase and saturates the sum.
// Depends on fts_pkg.
module fts_final
    import fts_pkg::*;
#(
    parameter int TERM_COUNT = TERM_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  fts_link_t                link_in,
    output logic                     done,
    output logic signed [SINE_W-1:0] sine_value
);

    localparam logic [1:0]          PHASE  = 2'((TERM_COUNT - 1) % 4);
    localparam logic signed [SUM_W:0] SAT_HI = (SUM_W+1)'(SINE_MAX);
    localparam logic signed [SUM_W:0] SAT_LO = (SUM_W+1)'(SINE_MIN);

    logic signed [SUM_W:0]    term_s;
    logic signed [SUM_W:0]    sum_ext;
    logic signed [SUM_W:0]    total;
    logic signed [SINE_W-1:0] value_next;
    logic                     done_reg;
    logic signed [SINE_W-1:0] value_reg;

    always_comb
    begin
        sum_ext = (SUM_W+1)'(link_in.sum);
        term_s  = link_in.t_neg ? -$signed((SUM_W+1)'(link_in.t_mag))
                                : $signed((SUM_W+1)'(link_in.t_mag));
        case (PHASE)
            PHASE_ADD: total = sum_ext + term_s;
            PHASE_SUB: total = sum_ext - term_s;
            default:   total = sum_ext;
        endcase

        if (total > SAT_HI)
        begin
            value_next = SINE_W'(SAT_HI);
        end
        else if (total < SAT_LO)
        begin
            value_next = SINE_W'(SAT_LO);
        end
        else
        begin
            value_next = total[SINE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            done_reg  <= link_in.valid;
            value_reg <= value_next;
        end
    end

    assign done       = done_reg;
    assign sine_value = value_reg;

endmodule

// ===== hw/rtl/fts_checker.sv =====
// Port-level checks of the Taylor-series sine block, bound to its top level.
// Depends on fts_pkg and fixed_point_taylor_sine_defines.svh.
`include "fixed_point_taylor_sine_defines.svh"

module fts_checker
    import fts_pkg::*;
#(
    parameter int TERM_COUNT = TERM_COUNT_DEF
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic signed [ANGLE_W-1:0] angle,
    input logic                      done,
    input logic signed [SINE_W-1:0]  sine_value
);

    localparam int LAT = 2 * TERM_COUNT;

    logic in_xfer;
    assign in_xfer = start && !busy;

    `FTS_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised on a chain that takes every cycle")
    `FTS_ASSERT_IMPLY(a_angle_known, clk, rst_n, in_xfer, !$isunknown(angle), "angle unknown")
    `FTS_ASSERT_IMPLY(a_result_follows, clk, rst_n, in_xfer, ##LAT done, "accepted angle gave no result")
    `FTS_ASSERT_IMPLY(a_result_has_cause, clk, rst_n, done, $past(in_xfer, LAT), "result without an angle")
    `FTS_ASSERT_IMPLY(a_result_bounded, clk, rst_n, done, (sine_value <= 18'sd70000) && (sine_value >= -18'sd70000), "sine outside one")

endmodule

bind fixed_point_taylor_sine fts_checker #(
    .TERM_COUNT (TERM_COUNT)
) u_fts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .angle      (angle),
    .done       (done),
    .sine_value (sine_value)
);

// ===== tb/sv/sine_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Taylor-series sine block: predicts each sine from the angle taken
// in and compares it with the value the block strobes out. Depends on fts_pkg.
module sine_checker
    import fts_pkg::*;
#(
    parameter int TERM_COUNT = TERM_COUNT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic                      done,
    input  logic signed [SINE_W-1:0]  sine_value,
    output int                        errors,
    output int                        pending
);

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [SINE_W-1:0]  sine;
    } sine_expect_t;

    sine_expect_t sine_q[$];

    // Series sine of a signed Q2.16 angle: operands of each product truncate toward zero
    // by 256, each division by the term index truncates toward zero.
    function automatic logic signed [SINE_W-1:0] taylor_sine(
        input logic signed [ANGLE_W-1:0] a
    );
        longint     x;
        longint     term;
        longint     acc;
        int         k;
        logic [1:0] phase;
        x = a;
        if (x > ANGLE_LIMIT)
            x = ANGLE_LIMIT;
        if (x < -ANGLE_LIMIT)
            x = -ANGLE_LIMIT;
        term = ONE_Q16;
        acc = 0;
        for (k = 1; k < TERM_COUNT; k++)
        begin
            term = ((x / 256) * (term / 256)) / k;
            phase = k[1:0];
            if (phase == PHASE_ADD)
                acc = acc + term;
            else if (phase == PHASE_SUB)
                acc = acc - term;
        end
        if (acc > SINE_MAX)
            acc = SINE_MAX;
        if (acc < SINE_MIN)
            acc = SINE_MIN;
        return acc[SINE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sine_expect_t item;
        sine_expect_t head;
        if (!rst_n)
        begin
            sine_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                item.angle = angle;
                item.sine  = taylor_sine(angle);
                sine_q.push_back(item);
            end
            if (done)
            begin
                if (sine_q.size() == 0)
                begin
                    $display("%0t: sine_value %0d strobed with no transfer outstanding",
                             $time, sine_value);
                    errors <= errors + 1;
                end
                else
                begin
                    head = sine_q.pop_front();
                    if (sine_value !== head.sine)
                    begin
                        $display("%0t: angle %0d sine_value expected %0d actual %0d",
                                 $time, head.angle, head.sine, sine_value);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= sine_q.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the sine testbench: clock, reset, angle stimulus, watchdog and verdict.
// Depends on fts_pkg, fixed_point_taylor_sine and sine_checker.
module testbench;
    import fts_pkg::*;

    localparam int TERMS       = TERM_COUNT_DEF;
    localparam int LATENCY     = 2 * TERMS;
    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT = 4000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [ANGLE_W-1:0] angle;
    logic                      done;
    logic signed [SINE_W-1:0]  sine_value;
    int                        errors;
    int                        pending;
    bit                        idle_on;
    int                        quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fixed_point_taylor_sine #(.TERM_COUNT(TERMS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .angle      (angle),
        .done       (done),
        .sine_value (sine_value)
    );

    sine_checker #(.TERM_COUNT(TERMS)) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .angle      (angle),
        .done       (done),
        .sine_value (sine_value),
        .errors     (errors),
        .pending    (pending)
    );

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("fixed_point_taylor_sine verification failed");
            $finish;
        end
    end

    // Called right after a rising edge; returns at the edge that takes the angle.
    task automatic send_angle(input logic signed [ANGLE_W-1:0] a);
        while (idle_on && $urandom_range(99) < 36)
        begin
            start <= 1'b0;
            angle <= ANGLE_W'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        angle <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Holds the input channel quiet until every transfer has produced its sine.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [ANGLE_W-1:0] random_angle;
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 70)
            v = int'($urandom_range(2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
        else if (sel < 85)
            v = $urandom;
        else if (sel < 93)
            v = int'($urandom_range(1023)) - 512;
        else
        begin
            // Close to the clamp on either side.
            v = ANGLE_LIMIT - 4 + int'($urandom_range(8));
            if ($urandom_range(1))
                v = -v;
        end
        return v[ANGLE_W-1:0];
    endfunction

    initial
    begin
        int corner[$];
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        angle = '0;
        idle_on = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero, tiny values, truncation boundaries, quarter turns, the clamp and
        // the ends of the field.
        corner = '{0, 1, -1, 255, -255, 256, -256, 511, -511, 65536, -65536,
                   102944, -102944, 205886, -205886, 205887, -205887,
                   205888, -205888, 262143, -262144, 131072, -131072};
        foreach (corner[j])
            send_angle(ANGLE_W'(corner[j]));
        drain();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // A long burst with the input channel never idle.
            idle_on = !(i >= 300 && i < 450);
            if (i == 500)
                drain();
            send_angle(random_angle());
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("fixed_point_taylor_sine verification clean");
        else
            $display("fixed_point_taylor_sine verification failed");
        $finish;
    end

endmodule
